// File: hdl/aplq_pkg.sv
package aplq_pkg;

    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 32;
    localparam int PROD_W   = 64;
    localparam int KEEP_W   = 52;   // product bits below the saturation limit
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = 36;
    localparam int STEPS    = RAD_W / 2;
    localparam int R1_W     = 26;   // root of a 52-bit product
    localparam int HI_W     = KEEP_W - 32;
    localparam int OFF_W    = 16;
    localparam int Q_W      = 16;
    localparam logic [16:0] QMAX_MAG = 17'd32767;
    localparam logic [OFF_W-1:0] OFFSET_RESET = 16'd26568;

    typedef struct packed {
        logic              neg;
        logic              last;
        logic              sat;
        logic [KEEP_W-1:0] keep;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  x;
        side_t             side;
    } sq_t;

endpackage

// File: hdl/aplq_sqrt_cell.sv
module aplq_sqrt_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         valid_in,
    input  aplq_pkg::sq_t data_in,
    output logic         valid_out,
    output aplq_pkg::sq_t data_out
);
    import aplq_pkg::*;

    logic             valid_reg;
    sq_t              data_reg;
    sq_t              data_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // one restoring step: bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh = {data_in.rem[REM_W-3:0], data_in.x[RAD_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, data_in.root, 2'b01};
        ge     = (rem_sh >= trial);
        data_next      = data_in;
        data_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        data_next.root = {data_in.root[ROOT_W-2:0], ge};
        data_next.x    = {data_in.x[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// File: hdl/aplq_sqrt_chain.sv
module aplq_sqrt_chain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid_in,
    input  logic [aplq_pkg::RAD_W-1:0]     rad_in,
    input  aplq_pkg::side_t                side_in,
    output logic                           valid_out,
    output logic [aplq_pkg::ROOT_W-1:0]    root_out,
    output aplq_pkg::side_t                side_out
);
    import aplq_pkg::*;

    logic valid_w [0:STEPS];
    sq_t  data_w  [0:STEPS];

    assign valid_w[0]     = valid_in;
    assign data_w[0].rem  = '0;
    assign data_w[0].root = '0;
    assign data_w[0].x    = rad_in;
    assign data_w[0].side = side_in;

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_cell
            aplq_sqrt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (valid_w[k]),
                .data_in   (data_w[k]),
                .valid_out (valid_w[k+1]),
                .data_out  (data_w[k+1])
            );
        end
    endgenerate

    assign valid_out = valid_w[STEPS];
    assign root_out  = data_w[STEPS].root;
    assign side_out  = data_w[STEPS].side;

endmodule

// File: hdl/aac_power_law_quantizer.sv
// pipeline from input request to result: 4 + 32 + 32 cell stages + output register
// throughput: one request per cycle while the output is not stalled; the whole pipe advances together
// each square root is a row of 32 cells, one root bit per cell
// reset: rst_n async active low clears all valid bits; rounding_offset returns to 26568
// a stalled output freezes every stage and drops s_axis_tready
module aac_power_law_quantizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // sample [31:0], band_gain [63:32]
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // quant_value [15:0]
    output logic        m_axis_tuser,   // saturated
    output logic        m_axis_tlast,   // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // rounding_offset
);
    import aplq_pkg::*;

    logic             en;
    logic [OFF_W-1:0] offset_reg;

    // stage 0: sign and magnitude
    logic              v0_reg;
    logic [31:0]       mag_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              neg0_reg;
    logic              last0_reg;
    // stage 1: product
    logic              v1_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg1_reg;
    logic              last1_reg;
    side_t             side1;
    // first root
    logic              v2;
    logic [ROOT_W-1:0] r_root;
    side_t             side2;
    // stage 2: partial products of p * r
    logic              v3_reg;
    logic [HI_W+R1_W-1:0] hir_reg;
    logic [32+R1_W-1:0]   lor_reg;
    side_t             side3_reg;
    // stage 3: t
    logic              v4_reg;
    logic [RAD_W-1:0]  t_reg;
    side_t             side4_reg;
    // second root
    logic              v5;
    logic [ROOT_W-1:0] v_root;
    side_t             side5;
    // output register
    logic              out_valid_reg;
    logic [Q_W-1:0]    out_q_reg;
    logic              out_sat_reg;
    logic              out_last_reg;

    logic [ROOT_W:0]   sum;
    logic [16:0]       q_full;
    logic              sat_fin;
    logic [Q_W-1:0]    mag_fin;
    logic [Q_W-1:0]    q_signed;
    logic [31:0]       sample_in;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign sample_in     = s_axis_tdata[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            offset_reg <= cfg_data;
        end
    end

    // control: valid bits of the non-cell stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= s_axis_tvalid;
            v1_reg        <= v0_reg;
            v3_reg        <= v2;
            v4_reg        <= v3_reg;
            out_valid_reg <= v5;
        end
    end

    // negating the most negative sample yields 2^31, which is what we want
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= sample_in[31] ? (32'd0 - sample_in) : sample_in;
            gain_reg  <= s_axis_tdata[63:32];
            neg0_reg  <= sample_in[31];
            last0_reg <= s_axis_tlast;
            prod_reg  <= 64'(mag_reg) * 64'(gain_reg);
            neg1_reg  <= neg0_reg;
            last1_reg <= last0_reg;
        end
    end

    // a product at or above 2^52 saturates for sure
    always_comb
    begin
        side1.neg  = neg1_reg;
        side1.last = last1_reg;
        side1.sat  = |prod_reg[PROD_W-1:KEEP_W];
        side1.keep = prod_reg[KEEP_W-1:0];
    end

    aplq_sqrt_chain u_root_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v1_reg),
        .rad_in    ({{(RAD_W-KEEP_W){1'b0}}, prod_reg[KEEP_W-1:0]}),
        .side_in   (side1),
        .valid_out (v2),
        .root_out  (r_root),
        .side_out  (side2)
    );

    // p * r / 2^16 split into high and low halves of p
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hir_reg   <= side2.keep[KEEP_W-1:32] * r_root[R1_W-1:0];
            lor_reg   <= side2.keep[31:0] * r_root[R1_W-1:0];
            side3_reg <= side2;
            t_reg     <= {2'b00, hir_reg, 16'd0}
                       + {{(RAD_W-(32+R1_W-16)){1'b0}}, lor_reg[32+R1_W-1:16]};
            side4_reg <= side3_reg;
        end
    end

    aplq_sqrt_chain u_root_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v4_reg),
        .rad_in    (t_reg),
        .side_in   (side4_reg),
        .valid_out (v5),
        .root_out  (v_root),
        .side_out  (side5)
    );

    // rounding, clipping and sign
    always_comb
    begin
        sum      = {1'b0, v_root} + {{(ROOT_W+1-OFF_W){1'b0}}, offset_reg};
        q_full   = sum[ROOT_W:16];
        sat_fin  = side5.sat || (q_full > QMAX_MAG);
        mag_fin  = sat_fin ? QMAX_MAG[Q_W-1:0] : q_full[Q_W-1:0];
        q_signed = side5.neg ? (16'd0 - mag_fin) : mag_fin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_q_reg    <= q_signed;
            out_sat_reg  <= sat_fin;
            out_last_reg <= side5.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_q_reg;
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: tb/aplq_checker.sv
`timescale 1ns / 1ps

module aplq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import aplq_pkg::*;

    typedef struct packed {
        logic [15:0] quant;
        logic        sat;
        logic        last;
    } quant_res_t;

    quant_res_t             quant_q[$];
    logic [OFF_W-1:0]       offset_reg;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic quant_res_t quantize(input logic [31:0] smp, input logic [31:0] gain,
                                            input logic lst, input logic [15:0] off);
        quant_res_t  o;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] q;
        neg = smp[31];
        mag = neg ? {32'd0, -smp} : {32'd0, smp};
        if (neg && mag == 0)
            mag = 64'h8000_0000;
        p     = mag * {32'd0, gain};
        o.sat = 1'b0;
        if (p >= (64'd1 << 52))
        begin
            q     = 32767;
            o.sat = 1'b1;
        end
        else
        begin
            r = isqrt64(p);
            t = (((p >> 32) * r) << 16) + (((p & 64'hFFFF_FFFF) * r) >> 16);
            q = (isqrt64(t) + off) >> 16;
            if (q > 32767)
            begin
                q     = 32767;
                o.sat = 1'b1;
            end
        end
        o.quant = neg ? -q[15:0] : q[15:0];
        o.last  = lst;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quant_res_t exp_r;
        if (!rst_n)
        begin
            offset_reg = OFFSET_RESET;
            fail_count = 0;
            quant_q.delete();
        end
        else
        begin
            // results first so a same-edge input never stands in front
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (quant_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = quant_q.pop_front();
                    if (exp_r.quant !== m_axis_tdata)
                    begin
                        $display("%0t: quant_value exp %h got %h", $time, exp_r.quant,
                                 m_axis_tdata);
                        fail_count++;
                    end
                    if (exp_r.sat !== m_axis_tuser)
                    begin
                        $display("%0t: saturated exp %b got %b", $time, exp_r.sat,
                                 m_axis_tuser);
                        fail_count++;
                    end
                    if (exp_r.last !== m_axis_tlast)
                    begin
                        $display("%0t: last exp %b got %b", $time, exp_r.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                quant_q.push_back(quantize(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                           s_axis_tlast, offset_reg));
            if (cfg_valid && cfg_ready)
                offset_reg = cfg_data;
        end
        pending = quant_q.size();
    end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // sample [31:0], band_gain [63:32]
    logic        s_axis_tlast;     // last_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // quant_value [15:0]
    logic        m_axis_tuser;     // saturated
    logic        m_axis_tlast;     // last_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;         // rounding_offset
    int          fail_count;
    int          pending;
    int          cycle_count;

    aac_power_law_quantizer u_dut (.*);
    aplq_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit: ~900 items each with the longest random gaps on both sides plus latency, many times over
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stalls, with calm stretches of always-ready
    initial
    begin
        int waitc;
        int calm;
        m_axis_tready = 1'b0;
        calm          = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tready && m_axis_tvalid)
            begin
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 19) == 0)
                    calm = $urandom_range(20, 80);
                waitc = (calm > 0) ? 0 : $urandom_range(0, 14);
                if (waitc > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (waitc - 1) @(posedge clk);
                    @(posedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_coef(input logic [31:0] smp, input logic [31:0] gain, input logic lst,
                             input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {gain, smp};
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_offset(input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random gain: mostly near unity-ish so results land in range, sometimes wild
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom_range(32'h0000_4000, 32'h0002_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = $urandom_range(0, 32'h0040_0000);
            default: v = $urandom_range(0, 32'h0800_0000);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    initial
    begin
        logic [15:0] offsets [0:4];
        int          n;
        offsets[0]    = 16'd26568;
        offsets[1]    = 16'd0;
        offsets[2]    = 16'hFFFF;
        offsets[3]    = 16'h8000;
        offsets[4]    = 16'd26568;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero, most negative, saturating products
        send_coef(32'h0000_0000, 32'h0001_0000, 1'b0, 0);
        send_coef(32'h8000_0000, 32'h0001_0000, 1'b1, 0);
        send_coef(32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 0);
        send_coef(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
        send_coef(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 0);
        send_coef(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 0);
        send_coef(32'h0000_0001, 32'h0000_0001, 1'b1, 0);
        send_coef(32'h0001_0000, 32'h0001_0000, 1'b0, 0);
        send_coef(32'hFFFF_0000, 32'h0001_0000, 1'b0, 0);
        send_coef(32'h0010_0000, 32'h0001_0000, 1'b1, 0);   // product at 2^36
        send_coef(32'h000F_FFFF, 32'h0001_0000, 1'b0, 0);   // just under
        send_coef(32'hFFF0_0001, 32'h0001_0000, 1'b0, 0);
        send_coef(32'h0009_FFFF, 32'h0001_0000, 1'b1, 0);   // product 0x9_FFFF_0000, well below the clip
        send_coef(32'h000A_2000, 32'h0001_0000, 1'b0, 0);
        send_coef(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0);
        send_coef(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 0);
        // every expected result has to come before the sender goes on
        drain_pipe();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_offset(offsets[ph]);
            send_coef(32'h0000_0000, 32'h0001_0000, 1'b0, 0);
            send_coef(32'h0001_0000, 32'h0001_0000, 1'b1, 0);
            n = (ph == 4) ? 260 : 160;
            for (int i = 0; i < n; i++)
                send_coef(pick_sample(), pick_gain(), $urandom_range(0, 1),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
            drain_pipe();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
